// ===== sv/cmbe_pkg.sv =====
// ----------------------------------------------------------------------------
// cmbe_pkg
// Shared types and constants of the colour mask boundary extract unit.
// ----------------------------------------------------------------------------
package cmbe_pkg;

   // Pixel channel, result and geometry widths
   localparam int PIX_W      = 8;
   localparam int ROW_W      = 12;
   localparam int HEIGHT_W   = 13;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 13;

   localparam logic [HEIGHT_W-1:0] HEIGHT_LIMIT = 13'd4096;
   localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;
   localparam int                  WIDTH_RESET  = 640;

   localparam logic [PIX_W-1:0] EDGE_ON  = 8'hFF;
   localparam logic [PIX_W-1:0] EDGE_OFF = 8'h00;

   // Item kinds on tuser
   localparam logic FUNC_PIXEL = 1'b0;
   localparam logic FUNC_DRAIN = 1'b1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BLUE_LOW     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLUE_HIGH    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GREEN_LOW    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GREEN_HIGH   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RED_LOW      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_RED_HIGH     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 3'd7;

   // Result queue
   localparam int OFIFO_DEPTH = 4;
   localparam int OFIFO_AW    = 2;
   localparam int OFIFO_CW    = 3;

   // Control of one step into the line store pipeline
   typedef struct packed {
      logic valid;
      logic produce;   // this step releases a result
      logic mask_bit;  // mask value of the entering position
      logic last_out;  // released result closes the frame
   } step_ctl_type;

   // One result on its way to the output
   typedef struct packed {
      logic edge_bit;
      logic last;
   } res_type;

endpackage

// ===== sv/cmbe_ram.sv =====
// ----------------------------------------------------------------------------
// cmbe_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cmbe_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];
   logic [WIDTH-1:0] rd_data_ff;

   // read returns the old contents on a same-address write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/cmbe_window.sv =====
// ----------------------------------------------------------------------------
// cmbe_window
// Line store read-modify-write, column vectors and the cross erosion window.
// ----------------------------------------------------------------------------
module cmbe_window #(
   parameter int MAX_WIDTH = 2048,
   parameter int RADIUS    = 2
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  cmbe_pkg::step_ctl_type               step,
   input  logic [$clog2(MAX_WIDTH)-1:0]         step_col,
   input  logic [cmbe_pkg::ROW_W-1:0]           step_orow,
   input  logic [$clog2(MAX_WIDTH)-1:0]         step_ocol,
   input  logic [$clog2(MAX_WIDTH+1)-1:0]       img_w,
   input  logic [cmbe_pkg::HEIGHT_W-1:0]        img_h,
   output logic                                 res_valid,
   output cmbe_pkg::res_type                    res,
   output logic [1:0]                           pipe_busy
);

   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int WW  = $clog2(MAX_WIDTH + 1);
   localparam int HW  = 2 * RADIUS;       // rows of history per column
   localparam int VW  = 2 * RADIUS + 1;   // column vector, bit 0 newest row
   localparam int WN  = 2 * RADIUS + 1;   // window entries, 0 newest
   localparam int RSW = cmbe_pkg::ROW_W + 2;
   localparam int CSW = WW + 1;

   // Stage A: store data back, column vector built and written
   cmbe_pkg::step_ctl_type     a_ctl_ff, a_ctl_in;
   logic [CW-1:0]              a_col_ff;
   logic [cmbe_pkg::ROW_W-1:0] a_orow_ff;
   logic [CW-1:0]              a_ocol_ff;
   logic                       fwd_sel_ff, fwd_sel_in;
   logic [HW-1:0]              fwd_data_ff;

   // Stage B: window holds the output position's neighbourhood
   logic                       b_valid_ff, b_valid_in;
   logic                       b_produce_ff;
   logic                       b_last_ff;
   logic [cmbe_pkg::ROW_W-1:0] b_orow_ff;
   logic [CW-1:0]              b_ocol_ff;
   logic [VW-1:0]              win_ff [0:WN-1];

   logic [HW-1:0]              rd_data;
   logic [HW-1:0]              hist;
   logic [VW-1:0]              colvec;
   logic [HW-1:0]              wr_data;

   logic                       centre;
   logic                       eroded;

   cmbe_ram #(
      .WIDTH (HW),
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (a_ctl_ff.valid),
      .wr_addr (a_col_ff),
      .wr_data (wr_data),
      .rd_en   (step.valid),
      .rd_addr (step_col),
      .rd_data (rd_data)
   );

   // Column vector: history of the column plus the entering row
   always_comb begin
      hist       = fwd_sel_ff ? fwd_data_ff : rd_data;
      colvec     = {hist, a_ctl_ff.mask_bit};
      wr_data    = colvec[HW-1:0];
      // back-to-back steps on one column: previous write is not yet visible
      fwd_sel_in = step.valid && a_ctl_ff.valid && (a_col_ff == step_col);
      a_ctl_in   = step;
      b_valid_in = a_ctl_ff.valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ctl_ff   <= '0;
         b_valid_ff <= 1'b0;
         fwd_sel_ff <= 1'b0;
      end else begin
         a_ctl_ff   <= a_ctl_in;
         b_valid_ff <= b_valid_in;
         fwd_sel_ff <= fwd_sel_in;
      end
   end

   // Payload of both stages and the window shift
   always_ff @(posedge clock) begin
      a_col_ff     <= step_col;
      a_orow_ff    <= step_orow;
      a_ocol_ff    <= step_ocol;
      fwd_data_ff  <= wr_data;
      b_produce_ff <= a_ctl_ff.produce;
      b_last_ff    <= a_ctl_ff.last_out;
      b_orow_ff    <= a_orow_ff;
      b_ocol_ff    <= a_ocol_ff;
      if (a_ctl_ff.valid) begin
         win_ff[0] <= colvec;
         for (int i = 1; i < WN; i++) begin
            win_ff[i] <= win_ff[i-1];
         end
      end
   end

   // Cross erosion; positions outside the image count as set
   always_comb begin
      logic up_ok;
      logic dn_ok;
      logic lt_ok;
      logic rt_ok;
      centre = win_ff[RADIUS][RADIUS];
      eroded = centre;
      for (int d = 1; d <= RADIUS; d++) begin
         up_ok = win_ff[RADIUS][RADIUS+d] || (RSW'(b_orow_ff) < RSW'(d));
         dn_ok = win_ff[RADIUS][RADIUS-d] ||
                 ((RSW'(b_orow_ff) + RSW'(d)) >= RSW'(img_h));
         rt_ok = win_ff[RADIUS-d][RADIUS] ||
                 ((CSW'(b_ocol_ff) + CSW'(d)) >= CSW'(img_w));
         lt_ok = win_ff[RADIUS+d][RADIUS] || (CSW'(b_ocol_ff) < CSW'(d));
         eroded = eroded && up_ok && dn_ok && rt_ok && lt_ok;
      end
   end

   assign res_valid    = b_valid_ff && b_produce_ff;
   assign res.edge_bit = centre && !eroded;
   assign res.last     = b_last_ff;
   assign pipe_busy    = {1'b0, a_ctl_ff.valid} + {1'b0, b_valid_ff};

endmodule

// ===== sv/cmbe_ofifo.sv =====
// ----------------------------------------------------------------------------
// cmbe_ofifo
// Small result queue between the window pipeline and the rsp channel.
// ----------------------------------------------------------------------------
module cmbe_ofifo (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             push,
   input  cmbe_pkg::res_type                push_data,
   input  logic                             pop_ready,
   output logic                             out_valid,
   output cmbe_pkg::res_type                out_data,
   output logic [cmbe_pkg::OFIFO_CW-1:0]    count
);

   cmbe_pkg::res_type                 ent_ff [0:cmbe_pkg::OFIFO_DEPTH-1];
   logic [cmbe_pkg::OFIFO_AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [cmbe_pkg::OFIFO_AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [cmbe_pkg::OFIFO_CW-1:0]     cnt_ff, cnt_in;
   logic                              pop;

   // Pointer and fill update; space is guaranteed by the upstream credit
   always_comb begin
      pop       = out_valid && pop_ready;
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign out_valid = (cnt_ff != '0);
   assign out_data  = ent_ff[rd_ptr_ff];
   assign count     = cnt_ff;

endmodule

// ===== sv/color_mask_boundary_extract_unit.sv =====
// ----------------------------------------------------------------------------
// color_mask_boundary_extract_unit
// Colour-threshold mask with cross erosion; emits the inner mask boundary.
// ----------------------------------------------------------------------------
// BGR pixels enter in raster order, one per clock while the result queue has
// room, and each is tested against the six inclusive channel bounds. The mask
// is eroded with a cross of reach RADIUS = CROSS_SIZE/2 (image border counts
// as set) and the result is 255 on pixels that are set but eroded away, else
// 0. The result for a position is released by the transaction RADIUS*width +
// RADIUS positions later; after the last pixel of a frame that many drain
// transactions (or pixels, which then count as drains) release the rest, and
// tlast marks the final result. The mask history lives in a line store of
// MAX_WIDTH entries, 2*RADIUS bits each, read and written once per
// transaction, so the sustained rate is one transaction per cycle while the
// queue has room. Frames with no more than RADIUS*width + RADIUS pixels stall
// req_tready after their last pixel while the rows below the image are run
// through the store. The store has no reset and no clearing pass.
// Configuration must be written between frames; the block does not enforce it.
// ----------------------------------------------------------------------------
module color_mask_boundary_extract_unit #(
   parameter int MAX_WIDTH  = 2048,
   parameter int CROSS_SIZE = 5
) (
   input  logic                                clock,
   input  logic                                reset,
   // pixel channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [23:0]                         req_tdata,  // blue, green, red
   input  logic                                req_tuser,  // func
   // result channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [cmbe_pkg::PIX_W-1:0]          rsp_tdata,  // edge_pixel
   output logic                                rsp_tlast,  // last_of_frame
   // configuration
   input  logic                                csr_wr_en,
   input  logic [cmbe_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [cmbe_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int RADIUS  = CROSS_SIZE / 2;
   localparam int CW      = $clog2(MAX_WIDTH);
   localparam int WW      = $clog2(MAX_WIDTH + 1);
   localparam int LAG_W   = $clog2(RADIUS * MAX_WIDTH + RADIUS + 1);
   localparam int W_RESET = (MAX_WIDTH < cmbe_pkg::WIDTH_RESET) ?
                            MAX_WIDTH : cmbe_pkg::WIDTH_RESET;
   localparam int HW_     = cmbe_pkg::HEIGHT_W;

   typedef enum logic [2:0] {
      PH_FILL    = 3'b001,   // frame pixels arriving
      PH_CATCHUP = 3'b010,   // run below the image until the owed result
      PH_DRAIN   = 3'b100    // one result per transaction
   } phase_type;

   // Configuration registers
   logic [cmbe_pkg::PIX_W-1:0] blue_low_ff, blue_high_ff;
   logic [cmbe_pkg::PIX_W-1:0] green_low_ff, green_high_ff;
   logic [cmbe_pkg::PIX_W-1:0] red_low_ff, red_high_ff;
   logic [WW-1:0]              w_ff, w_in;
   logic [HW_-1:0]             h_ff, h_in;

   // Sequencer state
   phase_type                  phase_ff, phase_in;
   logic [CW-1:0]              ic_ff, ic_in;
   logic [cmbe_pkg::ROW_W-1:0] ir_ff, ir_in;
   logic [CW-1:0]              oc_ff, oc_in;
   logic [cmbe_pkg::ROW_W-1:0] or_ff, or_in;
   logic [LAG_W-1:0]           cnt_ff, cnt_in;

   logic [LAG_W-1:0]           lag_value;
   logic                       room;
   logic                       in_range;
   logic                       ic_last, ir_last, oc_last, or_last;
   logic                       produce;
   cmbe_pkg::step_ctl_type     step;

   logic                       res_valid;
   cmbe_pkg::res_type          res;
   logic [1:0]                 pipe_busy;
   cmbe_pkg::res_type          head;
   logic [cmbe_pkg::OFIFO_CW-1:0] fifo_cnt;

   logic [cmbe_pkg::PIX_W-1:0] px_blue, px_green, px_red;
   logic [31:0]                wr_w_raw;

   // Width and height are clamped as they are written
   always_comb begin
      wr_w_raw = 32'(csr_wdata[11:0]);
      if (wr_w_raw == 32'd0) begin
         w_in = WW'(1);
      end else if (wr_w_raw > 32'(MAX_WIDTH)) begin
         w_in = WW'(MAX_WIDTH);
      end else begin
         w_in = WW'(wr_w_raw);
      end
      if (csr_wdata == '0) begin
         h_in = HW_'(1);
      end else if (csr_wdata > cmbe_pkg::HEIGHT_LIMIT) begin
         h_in = cmbe_pkg::HEIGHT_LIMIT;
      end else begin
         h_in = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blue_low_ff   <= '0;
         blue_high_ff  <= '1;
         green_low_ff  <= '0;
         green_high_ff <= '1;
         red_low_ff    <= '0;
         red_high_ff   <= '1;
         w_ff          <= WW'(W_RESET);
         h_ff          <= cmbe_pkg::HEIGHT_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            cmbe_pkg::CSR_BLUE_LOW:     blue_low_ff   <= csr_wdata[7:0];
            cmbe_pkg::CSR_BLUE_HIGH:    blue_high_ff  <= csr_wdata[7:0];
            cmbe_pkg::CSR_GREEN_LOW:    green_low_ff  <= csr_wdata[7:0];
            cmbe_pkg::CSR_GREEN_HIGH:   green_high_ff <= csr_wdata[7:0];
            cmbe_pkg::CSR_RED_LOW:      red_low_ff    <= csr_wdata[7:0];
            cmbe_pkg::CSR_RED_HIGH:     red_high_ff   <= csr_wdata[7:0];
            cmbe_pkg::CSR_IMAGE_WIDTH:  w_ff          <= w_in;
            cmbe_pkg::CSR_IMAGE_HEIGHT: h_ff          <= h_in;
            default: ;
         endcase
      end
   end

   // Threshold test and position flags
   always_comb begin
      px_blue   = req_tdata[7:0];
      px_green  = req_tdata[15:8];
      px_red    = req_tdata[23:16];
      in_range  = (px_blue >= blue_low_ff) && (px_blue <= blue_high_ff) &&
                  (px_green >= green_low_ff) && (px_green <= green_high_ff) &&
                  (px_red >= red_low_ff) && (px_red <= red_high_ff);
      lag_value = LAG_W'(RADIUS) * LAG_W'(w_ff) + LAG_W'(RADIUS);
      produce   = (cnt_ff == lag_value);
      ic_last   = (WW'(ic_ff) + WW'(1)) == w_ff;
      oc_last   = (WW'(oc_ff) + WW'(1)) == w_ff;
      ir_last   = (HW_'(ir_ff) + HW_'(1)) == h_ff;
      or_last   = (HW_'(or_ff) + HW_'(1)) == h_ff;
      room      = ({1'b0, fifo_cnt} + {2'b00, pipe_busy}) <
                  4'(cmbe_pkg::OFIFO_DEPTH);
   end

   // Handshake and step issue per phase
   always_comb begin
      req_tready     = 1'b0;
      step           = '0;
      step.produce   = produce;
      step.last_out  = produce && or_last && oc_last;
      unique case (phase_ff)
         PH_FILL: begin
            req_tready    = room;
            step.valid    = req_tvalid && room && (req_tuser == cmbe_pkg::FUNC_PIXEL);
            step.mask_bit = in_range;
         end
         PH_CATCHUP: begin
            step.valid    = room;
            step.mask_bit = 1'b1;
         end
         PH_DRAIN: begin
            req_tready    = room;
            step.valid    = req_tvalid && room;
            step.mask_bit = 1'b1;
         end
         default: ;
      endcase
   end

   // Position counters and phase sequencing
   always_comb begin
      phase_in = phase_ff;
      ic_in    = ic_ff;
      ir_in    = ir_ff;
      oc_in    = oc_ff;
      or_in    = or_ff;
      cnt_in   = cnt_ff;
      if (step.valid) begin
         ic_in = ic_last ? '0 : ic_ff + CW'(1);
         if (!produce) begin
            cnt_in = cnt_ff + LAG_W'(1);
         end else begin
            oc_in = oc_last ? '0 : oc_ff + CW'(1);
            if (oc_last) begin
               or_in = or_ff + cmbe_pkg::ROW_W'(1);
            end
         end
         unique case (phase_ff)
            PH_FILL: begin
               if (ic_last) begin
                  ir_in = ir_ff + cmbe_pkg::ROW_W'(1);
                  if (ir_last) begin
                     phase_in = produce ? PH_DRAIN : PH_CATCHUP;
                  end
               end
            end
            PH_CATCHUP: begin
               if (produce) begin
                  phase_in = PH_DRAIN;
               end
            end
            PH_DRAIN: ;
            default: ;
         endcase
         // final result of the frame: back to the origin
         if (step.last_out) begin
            phase_in = PH_FILL;
            ic_in    = '0;
            ir_in    = '0;
            oc_in    = '0;
            or_in    = '0;
            cnt_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_FILL;
         ic_ff    <= '0;
         ir_ff    <= '0;
         oc_ff    <= '0;
         or_ff    <= '0;
         cnt_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         ic_ff    <= ic_in;
         ir_ff    <= ir_in;
         oc_ff    <= oc_in;
         or_ff    <= or_in;
         cnt_ff   <= cnt_in;
      end
   end

   cmbe_window #(
      .MAX_WIDTH (MAX_WIDTH),
      .RADIUS    (RADIUS)
   ) u_window (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .step_col  (ic_ff),
      .step_orow (or_ff),
      .step_ocol (oc_ff),
      .img_w     (w_ff),
      .img_h     (h_ff),
      .res_valid (res_valid),
      .res       (res),
      .pipe_busy (pipe_busy)
   );

   cmbe_ofifo u_ofifo (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res),
      .pop_ready (rsp_tready),
      .out_valid (rsp_tvalid),
      .out_data  (head),
      .count     (fifo_cnt)
   );

   assign rsp_tdata = head.edge_bit ? cmbe_pkg::EDGE_ON : cmbe_pkg::EDGE_OFF;
   assign rsp_tlast = head.last;

endmodule
